### src/bed_pkg.sv
package bed_pkg;

  localparam int unsigned NumCh    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MsCfgW   = 16;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef logic [NumCh-1:0] ch_mask_t;
  typedef logic [TimeW-1:0] stamp_t;
  typedef logic [MsCfgW-1:0] ms_cfg_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FEATURE_EN  = 3'd0,
    CFG_DEBOUNCE    = 3'd1,
    CFG_LONG_PRESS  = 3'd2,
    CFG_DOUBLE      = 3'd3,
    CFG_COMBO_MSK_A = 3'd4,
    CFG_COMBO_HLD_A = 3'd5,
    CFG_COMBO_MSK_B = 3'd6,
    CFG_COMBO_HLD_B = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    COMBO_NONE = 2'd0,
    COMBO_A    = 2'd1,
    COMBO_B    = 2'd2
  } combo_e;

  // feature_enables bit positions
  localparam int unsigned FeatDebBit  = 0;
  localparam int unsigned FeatLongBit = 1;
  localparam int unsigned FeatDblBit  = 2;

endpackage

### src/bed_in_if.sv
interface bed_in_if
  import bed_pkg::*;
();
  logic     valid;
  logic     ready;
  ch_mask_t raw_levels;
  stamp_t   now_ms;

  modport source (output valid, output raw_levels, output now_ms, input ready);
  modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface

### src/bed_out_if.sv
interface bed_out_if
  import bed_pkg::*;
();
  logic              valid;
  logic              ready;
  ch_mask_t          press_events;
  ch_mask_t          release_events;
  ch_mask_t          double_events;
  ch_mask_t          long_events;
  logic [1:0]        combo_fired;
  ch_mask_t          held_mask;
  logic [CountW-1:0] held_count;

  modport source (
    output valid, output press_events, output release_events, output double_events,
    output long_events, output combo_fired, output held_mask, output held_count,
    input ready
  );
  modport sink (
    input valid, input press_events, input release_events, input double_events,
    input long_events, input combo_fired, input held_mask, input held_count,
    output ready
  );
endinterface

### src/button_event_detector.sv
// Pipeline: a tick is taken into the input register when accepted; the result
//   register loads from it when the result register is empty or being taken.
//   Per-channel subtract/compare and the combo check sit between the two registers.
// Throughput: one tick per cycle; the input is ready whenever the input register is
//   empty or its item moves on to the result register (empty or being taken).
// Reset: asynchronous, active low; clears channel and combo state, the pipeline
//   valids, and loads the default register values.
module button_event_detector
  import bed_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bed_in_if.sink              in_if,
  bed_out_if.source           out_if
);

  // configuration
  logic [2:0] feat_q;
  ms_cfg_t    deb_ms_q, long_ms_q, dbl_ms_q, hold_a_q, hold_b_q;
  ch_mask_t   mask_a_q, mask_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_q    <= 3'd7;
      deb_ms_q  <= 16'd50;
      long_ms_q <= 16'd1000;
      dbl_ms_q  <= 16'd300;
      mask_a_q  <= '0;
      hold_a_q  <= '0;
      mask_b_q  <= '0;
      hold_b_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FEATURE_EN:  feat_q    <= cfg_data_i[2:0];
        CFG_DEBOUNCE:    deb_ms_q  <= cfg_data_i;
        CFG_LONG_PRESS:  long_ms_q <= cfg_data_i;
        CFG_DOUBLE:      dbl_ms_q  <= cfg_data_i;
        CFG_COMBO_MSK_A: mask_a_q  <= cfg_data_i[NumCh-1:0];
        CFG_COMBO_HLD_A: hold_a_q  <= cfg_data_i;
        CFG_COMBO_MSK_B: mask_b_q  <= cfg_data_i[NumCh-1:0];
        CFG_COMBO_HLD_B: hold_b_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic     s1_valid_q;
  ch_mask_t raw_q;
  stamp_t   now_q;
  logic     out_valid_q;
  logic     out_free, s1_fire, in_fire;

  assign out_free     = !out_valid_q || out_if.ready;
  assign s1_fire      = s1_valid_q && out_free;
  assign in_if.ready  = !s1_valid_q || out_free;
  assign in_fire      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_q <= in_if.valid;
      if (out_free)    out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q <= in_if.raw_levels;
      now_q <= in_if.now_ms;
    end
  end

  // channel state
  ch_mask_t deb_q, deb_d, long_done_q, long_done_d;
  stamp_t   press_q [NumCh];
  stamp_t   press_d [NumCh];
  stamp_t   click_q [NumCh];
  stamp_t   click_d [NumCh];
  combo_e   active_q, active_d;
  stamp_t   start_q, start_d;

  ch_mask_t presses, releases, doubles, longs;
  logic [CountW-1:0] count;

  logic en_deb, en_long, en_dbl;
  assign en_deb  = feat_q[FeatDebBit];
  assign en_long = feat_q[FeatLongBit];
  assign en_dbl  = feat_q[FeatDblBit];

  always_comb begin
    logic   blocked, new_lvl, prev, done_eff;
    stamp_t press_eff;
    deb_d       = deb_q;
    long_done_d = long_done_q;
    presses     = '0;
    releases    = '0;
    doubles     = '0;
    longs       = '0;
    for (int i = 0; i < NumCh; i++) begin
      press_d[i] = press_q[i];
      click_d[i] = click_q[i];
      prev    = deb_q[i];
      // change inside the lockout: channel is frozen this tick
      blocked = en_deb && (raw_q[i] != prev) &&
                !((now_q - press_q[i]) > {16'd0, deb_ms_q});
      new_lvl = blocked ? prev : raw_q[i];
      deb_d[i] = new_lvl;
      press_eff = press_q[i];
      done_eff  = long_done_q[i];
      if (!blocked) begin
        if (new_lvl && !prev) begin
          press_eff  = now_q;
          done_eff   = 1'b0;
          press_d[i] = now_q;
          presses[i] = 1'b1;
          if (en_dbl) begin
            if ((now_q - click_q[i]) < {16'd0, dbl_ms_q}) begin
              doubles[i] = 1'b1;
              click_d[i] = '0;
            end else begin
              click_d[i] = now_q;
            end
          end
        end
        if (!new_lvl && prev) releases[i] = 1'b1;
        if (new_lvl && en_long && !done_eff &&
            (now_q - press_eff) >= {16'd0, long_ms_q}) begin
          done_eff = 1'b1;
          longs[i] = 1'b1;
        end
        long_done_d[i] = done_eff;
      end
    end
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < NumCh; i++) count = count + CountW'(deb_d[i]);
  end

  // combination check, first match in list order wins
  logic    match_a, match_b;
  combo_e  sel, fired;
  ms_cfg_t sel_hold;

  assign match_a = (mask_a_q != '0) && ((deb_d & mask_a_q) == mask_a_q);
  assign match_b = (mask_b_q != '0) && ((deb_d & mask_b_q) == mask_b_q);

  always_comb begin
    active_d = active_q;
    start_d  = start_q;
    fired    = COMBO_NONE;
    sel      = COMBO_NONE;
    sel_hold = '0;
    priority if (match_a) begin
      sel      = COMBO_A;
      sel_hold = hold_a_q;
    end else if (match_b) begin
      sel      = COMBO_B;
      sel_hold = hold_b_q;
    end else begin
      sel      = COMBO_NONE;
    end
    priority if (sel == COMBO_NONE) begin
      active_d = COMBO_NONE;
    end else if (active_q != sel) begin
      active_d = sel;
      start_d  = now_q;
    end else if (sel_hold != '0 && (now_q - start_q) < {16'd0, sel_hold}) begin
      fired = COMBO_NONE;
    end else begin
      active_d = COMBO_NONE;
      fired    = sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q       <= '0;
      long_done_q <= '0;
      active_q    <= COMBO_NONE;
      start_q     <= '0;
      for (int i = 0; i < NumCh; i++) begin
        press_q[i] <= '0;
        click_q[i] <= '0;
      end
    end else if (s1_fire) begin
      deb_q       <= deb_d;
      long_done_q <= long_done_d;
      active_q    <= active_d;
      start_q     <= start_d;
      for (int i = 0; i < NumCh; i++) begin
        press_q[i] <= press_d[i];
        click_q[i] <= click_d[i];
      end
    end
  end

  // result register
  ch_mask_t          press_ev_q, release_ev_q, double_ev_q, long_ev_q, held_q;
  logic [1:0]        combo_q;
  logic [CountW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      press_ev_q   <= presses;
      release_ev_q <= releases;
      double_ev_q  <= doubles;
      long_ev_q    <= longs;
      combo_q      <= fired;
      held_q       <= deb_d;
      count_q      <= count;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.press_events   = press_ev_q;
  assign out_if.release_events = release_ev_q;
  assign out_if.double_events  = double_ev_q;
  assign out_if.long_events    = long_ev_q;
  assign out_if.combo_fired    = combo_q;
  assign out_if.held_mask      = held_q;
  assign out_if.held_count     = count_q;

endmodule

### src/bed_checker.sv
module bed_checker
  import bed_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input ch_mask_t          press_i,
  input ch_mask_t          release_i,
  input ch_mask_t          double_i,
  input ch_mask_t          held_i,
  input logic [CountW-1:0] count_i
);

  // a double click is always also a press
  a_dbl_is_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((double_i & ~press_i) == '0))
    else $error("double event without press");

  // press shows up as held, release as not held
  a_edges_vs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (((press_i & ~held_i) == '0) && ((release_i & held_i) == '0)))
    else $error("edge disagrees with held mask");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (count_i == CountW'($countones(held_i))))
    else $error("held count mismatch");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(held_i) && $stable(press_i)))
    else $error("stalled item changed");

endmodule

bind button_event_detector bed_checker u_bed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .press_i     (out_if.press_events),
  .release_i   (out_if.release_events),
  .double_i    (out_if.double_events),
  .held_i      (out_if.held_mask),
  .count_i     (out_if.held_count)
);
